/* sv/cft_pkg.sv */
package cft_pkg;

  localparam int MAX_PENDING_DEF = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FIELDS_PER_RECORD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_HEADER       = 1'd1;

  localparam logic [3:0] FIELDS_RESET = 4'd5;
  localparam logic       SKIP_RESET   = 1'b1;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_COMMA = 8'd44;
  localparam logic [7:0] CH_QUOTE = 8'd34;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;

  localparam logic [7:0] TRIM_BYTES [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_QUOTE};

  typedef logic [1:0] op_t;
  localparam op_t OP_NONE    = 2'd0;
  localparam op_t OP_CONTENT = 2'd1;
  localparam op_t OP_CLOSE   = 2'd2;
  localparam op_t OP_LINE    = 2'd3;

  typedef struct packed {
    logic take;
    logic emit_flush;
    logic emit_byte;
    logic emit_mark;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    op_t  op;
    logic flush_nz;
    logic flush_done;
    logic mark_done;
    logic slot_free;
  } status_t;

  function automatic logic is_trim(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_QUOTE);
  endfunction

  function automatic logic [1:0] trim_code(input logic [7:0] b);
    logic [1:0] c;
    c = 2'd0;
    if (b == CH_TAB) c = 2'd1;
    if (b == CH_CR) c = 2'd2;
    if (b == CH_QUOTE) c = 2'd3;
    return c;
  endfunction

endpackage

/* sv/cft_byte_if.sv */
interface cft_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

/* sv/cft_result_if.sv */
interface cft_result_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] value;
  logic [3:0] field_index;
  logic       last;
  logic       overflow;

  modport source (output valid, output kind, output value, output field_index,
                  output last, output overflow, input ready);
  modport sink (input valid, input kind, input value, input field_index,
                input last, input overflow, output ready);
endinterface

/* sv/cft_cfg_if.sv */
interface cft_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [cft_pkg::CFG_IDX_W-1:0]  index;
  logic [cft_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/cft_ctrl.sv */
module cft_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  cft_pkg::status_t st,
  output cft_pkg::cmd_t    cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FLUSH = 2'd1;
  localparam logic [1:0] S_BYTE  = 2'd2;
  localparam logic [1:0] S_MARK  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (st.in_valid) begin
          case (st.op)
            cft_pkg::OP_CONTENT: state_next = st.flush_nz ? S_FLUSH : S_BYTE;
            cft_pkg::OP_CLOSE:   state_next = S_MARK;
            cft_pkg::OP_LINE:    state_next = S_MARK;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_FLUSH: begin
        cmd.emit_flush = st.slot_free;
        if (st.slot_free && st.flush_done) state_next = S_BYTE;
      end
      S_BYTE: begin
        cmd.emit_byte = st.slot_free;
        if (st.slot_free) state_next = S_IDLE;
      end
      S_MARK: begin
        cmd.emit_mark = st.slot_free;
        if (st.slot_free && st.mark_done) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* sv/cft_datapath.sv */
module cft_datapath #(
  parameter int MAX_PENDING = cft_pkg::MAX_PENDING_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cft_pkg::cmd_t    cmd,
  output cft_pkg::status_t st,
  cft_byte_if.sink         data,
  cft_result_if.source     result,
  cft_cfg_if.sink          cfg
);

  localparam int PW = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;
  localparam int CW = $clog2(MAX_PENDING + 1);

  localparam logic [2:0] M_START    = 3'd0;
  localparam logic [2:0] M_QUOTED   = 3'd1;
  localparam logic [2:0] M_UNQUOTED = 3'd2;
  localparam logic [2:0] M_QSEEN    = 3'd3;
  localparam logic [2:0] M_SKIP     = 3'd4;
  localparam logic [2:0] M_IGNORE   = 3'd5;

  logic [3:0]    fpr;
  logic          skip;
  logic [2:0]    mode, mode_next;
  logic [3:0]    fnum, fnum_next;
  logic          started, started_next;
  logic [CW-1:0] pcount, pcount_next;
  logic          hdone, hdone_next;
  logic          ovf, ovf_next;

  logic [1:0]    pend [MAX_PENDING];
  logic [1:0]    rd_data;
  logic [CW-1:0] rd_ptr, rd_ptr_next;
  logic [PW-1:0] rd_addr;

  logic [7:0]    cur_byte;
  logic [CW-1:0] flush_n;
  logic [3:0]    emit_fld;
  logic [3:0]    mark_end;

  logic          o_valid;
  logic          o_kind;
  logic [7:0]    o_value;
  logic [3:0]    o_fidx;
  logic          o_last;
  logic          o_ovf;

  logic          accept;
  logic [7:0]    b;
  logic [3:0]    kept;
  logic [3:0]    fnum_inc;
  logic          cont;
  logic [7:0]    cbyte;
  logic          push;
  cft_pkg::op_t  op;
  logic          emit;

  assign b = data.data_byte;
  assign accept = cmd.take && data.valid;
  assign data.ready = cmd.take;
  assign cfg.ready = 1'b1;
  assign emit = cmd.emit_flush || cmd.emit_byte || cmd.emit_mark;

  always_comb begin
    mode_next = mode;
    fnum_next = fnum;
    started_next = started;
    pcount_next = pcount;
    hdone_next = hdone;
    ovf_next = ovf;
    op = cft_pkg::OP_NONE;
    cont = 1'b0;
    cbyte = b;
    push = 1'b0;
    kept = (fpr == 4'd0) ? 4'd1 : fpr;
    fnum_inc = fnum + 4'd1;
    if (!hdone && skip) begin
      if (b == cft_pkg::CH_NL) hdone_next = 1'b1;
    end else if (fnum >= kept || (mode inside {[M_IGNORE:3'd7]})) begin
      if (b == cft_pkg::CH_NL) begin
        hdone_next = 1'b1;
        fnum_next = 4'd0;
        mode_next = M_START;
        started_next = 1'b0;
        pcount_next = '0;
      end else begin
        mode_next = M_IGNORE;
      end
    end else if (b == cft_pkg::CH_NL) begin
      op = cft_pkg::OP_LINE;
      hdone_next = 1'b1;
      fnum_next = 4'd0;
      mode_next = M_START;
      started_next = 1'b0;
      pcount_next = '0;
    end else if (b == cft_pkg::CH_COMMA && mode != M_QUOTED) begin
      op = cft_pkg::OP_CLOSE;
      started_next = 1'b0;
      pcount_next = '0;
      fnum_next = fnum_inc;
      mode_next = (fnum_inc >= kept) ? M_IGNORE : M_START;
    end else begin
      case (mode)
        M_START: begin
          if (b inside {cft_pkg::CH_SPACE, cft_pkg::CH_TAB}) begin
            mode_next = M_START;
          end else if (b == cft_pkg::CH_QUOTE) begin
            mode_next = M_QUOTED;
          end else begin
            mode_next = M_UNQUOTED;
            cont = 1'b1;
          end
        end
        M_QUOTED: begin
          if (b == cft_pkg::CH_QUOTE) mode_next = M_QSEEN;
          else cont = 1'b1;
        end
        M_QSEEN: begin
          if (b == cft_pkg::CH_QUOTE) begin
            cont = 1'b1;
            mode_next = M_QUOTED;
          end else begin
            mode_next = M_SKIP;
          end
        end
        M_UNQUOTED: cont = 1'b1;
        default: cont = 1'b0;
      endcase
    end
    if (cont) begin
      if (cft_pkg::is_trim(cbyte)) begin
        if (started) begin
          if (pcount < CW'(MAX_PENDING)) begin
            push = 1'b1;
            pcount_next = pcount + CW'(1);
          end else begin
            ovf_next = 1'b1;
          end
        end
      end else begin
        op = cft_pkg::OP_CONTENT;
        pcount_next = '0;
        started_next = 1'b1;
      end
    end
  end

  always_comb begin
    rd_ptr_next = rd_ptr;
    if (cmd.take) rd_ptr_next = '0;
    else if (cmd.emit_flush) rd_ptr_next = rd_ptr + CW'(1);
    rd_addr = (rd_ptr_next < CW'(MAX_PENDING)) ? rd_ptr_next[PW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (accept && push) pend[pcount[PW-1:0]] <= cft_pkg::trim_code(cbyte);
    rd_data <= pend[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fpr <= cft_pkg::FIELDS_RESET;
      skip <= cft_pkg::SKIP_RESET;
      mode <= M_START;
      fnum <= 4'd0;
      started <= 1'b0;
      pcount <= '0;
      hdone <= 1'b0;
      ovf <= 1'b0;
      rd_ptr <= '0;
      o_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          cft_pkg::REG_FIELDS_PER_RECORD: fpr <= cfg.data[3:0];
          cft_pkg::REG_SKIP_HEADER:       skip <= cfg.data[0];
          default: ;
        endcase
      end
      if (accept) begin
        mode <= mode_next;
        fnum <= fnum_next;
        started <= started_next;
        pcount <= pcount_next;
        hdone <= hdone_next;
        ovf <= ovf_next;
      end
      rd_ptr <= rd_ptr_next;
      if (emit) o_valid <= 1'b1;
      else if (result.ready) o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_byte <= cbyte;
      flush_n <= pcount;
      emit_fld <= fnum;
      mark_end <= (op == cft_pkg::OP_LINE) ? kept - 4'd1 : fnum;
    end
    if (cmd.emit_mark) emit_fld <= emit_fld + 4'd1;
    if (emit) begin
      o_ovf <= ovf;
      o_kind <= cmd.emit_mark;
      if (cmd.emit_mark) begin
        o_value <= 8'd0;
        o_fidx <= emit_fld;
        o_last <= (emit_fld == mark_end);
      end else if (cmd.emit_flush) begin
        o_value <= cft_pkg::TRIM_BYTES[rd_data];
        o_fidx <= fnum;
        o_last <= 1'b0;
      end else begin
        o_value <= cur_byte;
        o_fidx <= fnum;
        o_last <= 1'b1;
      end
    end
  end

  assign st.in_valid = data.valid;
  assign st.op = op;
  assign st.flush_nz = (pcount != '0);
  assign st.flush_done = ((rd_ptr + CW'(1)) == flush_n);
  assign st.mark_done = (emit_fld == mark_end);
  assign st.slot_free = !o_valid || result.ready;

  assign result.valid = o_valid;
  assign result.kind = o_kind;
  assign result.value = o_value;
  assign result.field_index = o_fidx;
  assign result.last = o_last;
  assign result.overflow = o_ovf;

  a_pcount_bound: assert property (@(posedge clk) disable iff (rst)
    pcount <= CW'(MAX_PENDING)) else $error("pending count beyond store");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    ovf |=> ovf) else $error("overflow flag cleared");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_kind |-> o_value == 8'd0 && o_fidx != 4'd15)
    else $error("bad end of field marker");

endmodule

/* sv/csv_field_tokenizer_top.sv */
// csv field tokenizer
// data: one csv byte per request (data_byte); newline ends a record
// result: one request per result: kind 0 content byte in value, kind 1
//   end of field marker; field_index, last on the final result of a byte,
//   and the sticky overflow flag
// cfg: register writes, index 0 fields_per_record, index 1 skip_header;
//   always ready, write only while the block is idle
// a byte that causes no result leaves the controller idle, ready for the
//   next byte; a byte that causes n results holds the controller until
//   all n are emitted, one result per cycle into the output register
//   while it is free; the first result is registered once out of idle
// n counts the flushed pending trim bytes plus the content byte, the
//   single marker of a comma, or the markers up to the kept field count
//   of a newline; pending entries are read one per cycle unless stalled
// when the receiver stalls, the output register holds its result and
//   the emitting state waits; input is not taken until the sequence ends
// reset: registers return to fields_per_record 5 and skip_header 1,
//   parser state to field start, no pending bytes, overflow cleared
module csv_field_tokenizer_top #(
  parameter int MAX_PENDING = cft_pkg::MAX_PENDING_DEF
) (
  input logic          clk,
  input logic          rst,
  cft_byte_if.sink     data,
  cft_result_if.source result,
  cft_cfg_if.sink      cfg
);

  cft_pkg::cmd_t    cmd;
  cft_pkg::status_t st;

  cft_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  cft_datapath #(
    .MAX_PENDING (MAX_PENDING)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .st     (st),
    .data   (data),
    .result (result),
    .cfg    (cfg)
  );

endmodule

/* sim/csv_field_tokenizer_top_tb.sv */
module csv_field_tokenizer_top_tb;

  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES   = 28;
  localparam int N_PHASES      = 8;
  localparam int N_DIRECTED    = 22;
  localparam int MAX_PRINTED   = 40;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_MARK = 1'b1;

  localparam logic [2:0] MODE_START    = 3'd0;
  localparam logic [2:0] MODE_QUOTED   = 3'd1;
  localparam logic [2:0] MODE_UNQUOTED = 3'd2;
  localparam logic [2:0] MODE_QSEEN    = 3'd3;
  localparam logic [2:0] MODE_SKIP     = 3'd4;
  localparam logic [2:0] MODE_IGNORE   = 3'd5;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic [3:0] field_index;
    logic       last;
    logic       overflow;
  } token_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    logic [4:0] n;
    logic       kind;
    logic [7:0] value;
    logic [3:0] idx;
  } row_t;

  // starts at reset settings: 5 fields kept, header line dropped
  localparam row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{8'h68,             1'b1, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{cft_pkg::CH_NL,    1'b1, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{8'h00,             1'b1, 5'd1, KIND_BYTE, 8'h00,             4'd0},
    '{8'hFF,             1'b1, 5'd1, KIND_BYTE, 8'hFF,             4'd0},
    '{cft_pkg::CH_SPACE, 1'b1, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{cft_pkg::CH_CR,    1'b1, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{8'h7A,             1'b0, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{cft_pkg::CH_COMMA, 1'b1, 5'd1, KIND_MARK, 8'h00,             4'd0},
    '{cft_pkg::CH_TAB,   1'b1, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{cft_pkg::CH_QUOTE, 1'b1, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{cft_pkg::CH_COMMA, 1'b1, 5'd1, KIND_BYTE, cft_pkg::CH_COMMA, 4'd1},
    '{cft_pkg::CH_QUOTE, 1'b1, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{cft_pkg::CH_QUOTE, 1'b1, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{8'h71,             1'b0, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{cft_pkg::CH_QUOTE, 1'b1, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{8'h6A,             1'b1, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{cft_pkg::CH_COMMA, 1'b1, 5'd1, KIND_MARK, 8'h00,             4'd1},
    '{cft_pkg::CH_QUOTE, 1'b1, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{8'h75,             1'b1, 5'd1, KIND_BYTE, 8'h75,             4'd2},
    '{cft_pkg::CH_NL,    1'b0, 5'd0, KIND_BYTE, 8'h00,             4'd0},
    '{cft_pkg::CH_COMMA, 1'b1, 5'd1, KIND_MARK, 8'h00,             4'd0},
    '{cft_pkg::CH_NL,    1'b0, 5'd0, KIND_BYTE, 8'h00,             4'd0}
  };

  localparam logic [3:0] PHASE_FIELDS [N_PHASES] = '{
    4'd15, 4'd0, 4'd1, 4'd7, 4'd2, 4'd15, 4'd3, 4'd5
  };
  localparam logic PHASE_SKIP [N_PHASES] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  cft_byte_if   data_ch();
  cft_result_if result_ch();
  cft_cfg_if    cfg_ch();

  csv_field_tokenizer_top DUT (
    .clk(clk),
    .rst(rst),
    .data(data_ch),
    .result(result_ch),
    .cfg(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [3:0]  kept_reg;
  logic        skip_hdr_reg;
  logic [2:0]  mode;
  logic [3:0]  field_no;
  logic        started;
  logic [7:0]  trail_run [$];
  logic        hdr_done;
  logic        ovf;

  token_t     tokens_due [$];
  row_t       row_notes [$];
  logic [7:0] csv_text [$];

  int errors;
  int quiet_cycles;
  bit calm;
  bit hold_req;

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) report_error($sformatf("%s: got %0h, want %0h", what, got, want));
  endtask

  function automatic logic trimmable(input logic [7:0] b);
    return b == cft_pkg::CH_SPACE || b == cft_pkg::CH_TAB || b == cft_pkg::CH_CR ||
           b == cft_pkg::CH_QUOTE;
  endfunction

  function automatic void push_token(input logic kind, input logic [7:0] val,
                                     input logic [3:0] idx);
    token_t t;
    t.kind = kind;
    t.value = val;
    t.field_index = idx;
    t.last = 1'b0;
    t.overflow = ovf;
    tokens_due.push_back(t);
  endfunction

  function automatic void add_content(input logic [7:0] b);
    if (trimmable(b)) begin
      if (started) begin
        if (trail_run.size() < cft_pkg::MAX_PENDING_DEF) trail_run.push_back(b);
        else ovf = 1'b1;
      end
    end else begin
      foreach (trail_run[i]) push_token(KIND_BYTE, trail_run[i], field_no);
      trail_run.delete();
      started = 1'b1;
      push_token(KIND_BYTE, b, field_no);
    end
  endfunction

  function automatic void close_field();
    push_token(KIND_MARK, 8'h00, field_no);
    started = 1'b0;
    trail_run.delete();
  endfunction

  // returns the number of tokens this byte adds to tokens_due
  function automatic int tokenize_byte(input logic [7:0] b);
    int before_n;
    int kept;
    int f;
    token_t t;
    before_n = tokens_due.size();
    kept = (kept_reg == 4'd0) ? 1 : int'(kept_reg);
    if (!hdr_done && skip_hdr_reg) begin
      if (b == cft_pkg::CH_NL) hdr_done = 1'b1;
      return 0;
    end
    if (int'(field_no) >= kept || mode > MODE_SKIP) begin
      if (b == cft_pkg::CH_NL) begin
        hdr_done = 1'b1;
        field_no = 4'd0;
        mode = MODE_START;
        started = 1'b0;
        trail_run.delete();
      end else begin
        mode = MODE_IGNORE;
      end
      return 0;
    end
    if (b == cft_pkg::CH_NL) begin
      hdr_done = 1'b1;
      close_field();
      for (f = int'(field_no) + 1; f < kept; f++) push_token(KIND_MARK, 8'h00, f[3:0]);
      field_no = 4'd0;
      mode = MODE_START;
    end else if (b == cft_pkg::CH_COMMA && mode != MODE_QUOTED) begin
      close_field();
      field_no = field_no + 4'd1;
      mode = (int'(field_no) >= kept) ? MODE_IGNORE : MODE_START;
    end else begin
      case (mode)
        MODE_START: begin
          if (b == cft_pkg::CH_QUOTE) begin
            mode = MODE_QUOTED;
          end else if (b != cft_pkg::CH_SPACE && b != cft_pkg::CH_TAB) begin
            mode = MODE_UNQUOTED;
            add_content(b);
          end
        end
        MODE_QUOTED: begin
          if (b == cft_pkg::CH_QUOTE) mode = MODE_QSEEN;
          else add_content(b);
        end
        MODE_QSEEN: begin
          if (b == cft_pkg::CH_QUOTE) begin
            add_content(cft_pkg::CH_QUOTE);
            mode = MODE_QUOTED;
          end else begin
            mode = MODE_SKIP;
          end
        end
        MODE_UNQUOTED: add_content(b);
        default: ;
      endcase
    end
    if (tokens_due.size() > before_n) begin
      t = tokens_due[tokens_due.size() - 1];
      t.last = 1'b1;
      tokens_due[tokens_due.size() - 1] = t;
    end
    return tokens_due.size() - before_n;
  endfunction

  // csv text generation
  function automatic logic [7:0] pick_char();
    logic [7:0] c;
    if ($urandom_range(0, 5) == 0) begin
      do c = 8'($urandom_range(0, 255));
      while (c == cft_pkg::CH_NL || c == cft_pkg::CH_COMMA);
    end else begin
      do c = 8'($urandom_range(33, 126));
      while (c == cft_pkg::CH_COMMA || c == cft_pkg::CH_QUOTE);
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_trim();
    case ($urandom_range(0, 3))
      0: return cft_pkg::CH_SPACE;
      1: return cft_pkg::CH_TAB;
      2: return cft_pkg::CH_CR;
      default: return cft_pkg::CH_QUOTE;
    endcase
  endfunction

  function automatic void add_field(input int sel, input bit long_run);
    int n;
    repeat ($urandom_range(0, 2)) begin
      csv_text.push_back($urandom_range(0, 1) ? cft_pkg::CH_SPACE : cft_pkg::CH_TAB);
    end
    if (sel >= 1 && sel <= 4) begin
      n = $urandom_range(1, 5);
      repeat (n) begin
        csv_text.push_back(pick_char());
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) csv_text.push_back(pick_trim());
      end
      if (long_run && $urandom_range(0, 2) == 0) begin
        repeat (cft_pkg::MAX_PENDING_DEF + $urandom_range(0, 3)) csv_text.push_back(pick_trim());
        csv_text.push_back(pick_char());
      end
      repeat ($urandom_range(0, 4)) csv_text.push_back(pick_trim());
    end else if (sel >= 5 && sel <= 7) begin
      csv_text.push_back(cft_pkg::CH_QUOTE);
      n = $urandom_range(0, 5);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0: csv_text.push_back(cft_pkg::CH_COMMA);
          1: begin
            csv_text.push_back(cft_pkg::CH_QUOTE);
            csv_text.push_back(cft_pkg::CH_QUOTE);
          end
          2: csv_text.push_back(cft_pkg::CH_SPACE);
          default: csv_text.push_back(pick_char());
        endcase
      end
      csv_text.push_back(cft_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 2)) csv_text.push_back(pick_char());
    end else if (sel == 8) begin
      // raw noise, newlines and commas included
      repeat ($urandom_range(1, 4)) csv_text.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void add_record(input int kept, input bit long_run, input bit partial);
    int nf;
    int sel;
    nf = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 16) : $urandom_range(1, kept);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) csv_text.push_back(cft_pkg::CH_COMMA);
      sel = $urandom_range(0, 9);
      if (sel == 9 && !partial) begin
        // quote left open up to the newline
        csv_text.push_back(cft_pkg::CH_QUOTE);
        repeat ($urandom_range(0, 3)) csv_text.push_back(pick_char());
        csv_text.push_back(cft_pkg::CH_NL);
        return;
      end
      add_field(sel, long_run);
    end
    if (!partial) csv_text.push_back(cft_pkg::CH_NL);
  endfunction

  // stimulus
  task automatic feed(input row_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      data_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    row_notes.push_back(r);
    data_ch.data_byte = r.b;
    data_ch.valid = 1'b1;
    do @(posedge clk); while (!data_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [cft_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cft_pkg::CFG_DATA_W-1:0] val);
    cfg_ch.index = idx;
    cfg_ch.data = val;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == cft_pkg::REG_FIELDS_PER_RECORD) kept_reg = val;
    else skip_hdr_reg = val[0];
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic drain();
    while (tokens_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // result side
  initial begin
    int stall;
    result_ch.ready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        result_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = calm ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      @(negedge clk);
    end
  end

  // scoreboard and watchdog
  always @(posedge clk) begin
    token_t got;
    token_t want;
    row_t note;
    int added;
    if (!rst) begin
      if (result_ch.valid && result_ch.ready) begin
        got.kind = result_ch.kind;
        got.value = result_ch.value;
        got.field_index = result_ch.field_index;
        got.last = result_ch.last;
        got.overflow = result_ch.overflow;
        if (tokens_due.size() == 0) begin
          report_error($sformatf("unexpected result kind %0d value %0h field %0d",
                                 got.kind, got.value, got.field_index));
        end else begin
          want = tokens_due.pop_front();
          check_field("kind", int'(got.kind), int'(want.kind));
          check_field("value", int'(got.value), int'(want.value));
          check_field("field_index", int'(got.field_index), int'(want.field_index));
          check_field("last", int'(got.last), int'(want.last));
          check_field("overflow", int'(got.overflow), int'(want.overflow));
        end
      end
      if (data_ch.valid && data_ch.ready) begin
        added = tokenize_byte(data_ch.data_byte);
        if (row_notes.size() != 0) begin
          note = row_notes.pop_front();
          if (note.typed) begin
            if (added != int'(note.n)) begin
              report_error($sformatf("byte %0h: %0d results predicted, table says %0d",
                                     note.b, added, note.n));
            end else if (added == 1) begin
              check_field("table kind", int'(tokens_due[$].kind), int'(note.kind));
              check_field("table value", int'(tokens_due[$].value), int'(note.value));
              check_field("table field_index", int'(tokens_due[$].field_index),
                          int'(note.idx));
            end
          end
        end
      end
      if ((data_ch.valid && data_ch.ready) || (result_ch.valid && result_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("csv_field_tokenizer_top: mismatch");
          $finish;
        end
      end
    end
  end

  initial begin
    int kept;
    row_t r;
    data_ch.valid = 1'b0;
    data_ch.data_byte = 8'h00;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    kept_reg = cft_pkg::FIELDS_RESET;
    skip_hdr_reg = cft_pkg::SKIP_RESET;
    mode = MODE_START;
    field_no = 4'd0;
    started = 1'b0;
    hdr_done = 1'b0;
    ovf = 1'b0;
    errors = 0;
    quiet_cycles = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    foreach (DIRECTED_ROWS[i]) feed(DIRECTED_ROWS[i]);
    data_ch.valid = 1'b0;
    drain();

    for (int p = 0; p < N_PHASES; p++) begin
      write_reg(cft_pkg::REG_FIELDS_PER_RECORD, PHASE_FIELDS[p]);
      write_reg(cft_pkg::REG_SKIP_HEADER, {{(cft_pkg::CFG_DATA_W-1){1'b0}}, PHASE_SKIP[p]});
      calm = (p % 3 == 2);
      kept = (PHASE_FIELDS[p] == 4'd0) ? 1 : int'(PHASE_FIELDS[p]);
      csv_text.delete();
      while (csv_text.size() < PHASE_BYTES) add_record(kept, p == N_PHASES - 1, 1'b0);
      // sometimes leave a record open across the register change
      if ($urandom_range(0, 1) == 1) add_record(kept, 1'b0, 1'b1);
      if (p == 0) hold_req = 1'b1;
      foreach (csv_text[i]) begin
        if (p == 3 && i == csv_text.size() / 2) begin
          data_ch.valid = 1'b0;
          while (tokens_due.size() != 0) @(negedge clk);
        end
        r = '0;
        r.b = csv_text[i];
        feed(r);
      end
      data_ch.valid = 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("csv_field_tokenizer_top: match");
    end else begin
      $display("csv_field_tokenizer_top: mismatch");
    end
    $finish;
  end

endmodule
